@@ sv/tts_pkg.sv @@
// Shared types and constants of the tick timer with its bank of stopwatches.
package tts_pkg;

    localparam int MAX_WATCHES_DEF = 16;

    localparam int TICK_W    = 64;
    localparam int RATE_W    = 14;
    localparam int ID_W      = 8;
    localparam int SLEEP_W   = 31;
    localparam int HI_W      = 14;
    localparam int WORK_W    = TICK_W + HI_W;
    localparam int MUL_STEPS = TICK_W;
    localparam int DIV_STEPS = WORK_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);
    localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(1);
    localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(10000);
    localparam logic [RATE_W-1:0] MS_PER_S   = RATE_W'(1000);
    localparam logic [TICK_W-1:0] ALL_ONES   = '1;

    typedef enum logic [2:0]
    {
        OP_TICK   = 3'd0,
        OP_SLEEP  = 3'd1,
        OP_CREATE = 3'd2,
        OP_START  = 3'd3,
        OP_STOP   = 3'd4,
        OP_RESET  = 3'd5,
        OP_READ   = 3'd6,
        OP_UPTIME = 3'd7
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_OK     = 2'd0,
        ST_BAD_ID = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed
    {
        opcode_t              opcode;
        logic [ID_W-1:0]      watch_id;
        logic [SLEEP_W-1:0]   sleep_ms;
    } cmd_t;

    typedef struct packed
    {
        status_t              status;
        logic [TICK_W-1:0]    value;
        logic                 is_running;
    } rsp_t;

endpackage

@@ sv/tts_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/tick_timer_stopwatch_bank_top.sv @@
// Top level of the tick timer with its bank of stopwatches.
//
// One command is taken at a time and gives exactly one response. A tick, a
// create, a zero-length sleep or a command with a bad id goes from idle to the
// done state, which loads the output register once it is free; start, reset,
// and a stop or read of a watch that is not running pass the RAM read state
// first. A non-zero sleep, an uptime read and (after the read state) a stop or
// read of a running watch go through one bit-serial unit that first multiplies
// by a 14-bit constant or the tick rate (64 steps, one multiplier bit a cycle),
// then divides the 78-bit product by the tick rate or by 1000 (78 restoring
// steps, one quotient bit a cycle), then passes a post state. The per-watch
// start tick, elapsed time and running flag live in one RAM with a registered
// read; a slot is cleared when it is created, so there is no clearing pass
// after reset. The tick rate may only be written while no command is in flight.
module tick_timer_stopwatch_bank_top #(
    parameter int MAX_WATCHES = tts_pkg::MAX_WATCHES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  tts_pkg::cmd_t               in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output tts_pkg::rsp_t               out_data,
    input  logic                        cfg_we,
    input  logic [tts_pkg::RATE_W-1:0]  cfg_data
);

    localparam int AW    = (MAX_WATCHES > 1) ? $clog2(MAX_WATCHES) : 1;
    localparam int AC_W  = $clog2(MAX_WATCHES + 1);
    localparam int ENT_W = 1 + 2 * tts_pkg::TICK_W;
    localparam int TW    = tts_pkg::TICK_W;
    localparam int WW    = tts_pkg::WORK_W;
    localparam int RW    = tts_pkg::RATE_W;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_RD,
        S_MUL,
        S_DIV,
        S_POST,
        S_DONE
    } state_t;

    state_t                    state_reg;
    tts_pkg::opcode_t          op_reg;
    logic [AW-1:0]             id_reg;
    logic [AC_W-1:0]           alloc_reg;
    logic [TW-1:0]             ticks_reg;
    logic [RW-1:0]             rate_reg;
    logic [WW-1:0]             w_reg;
    logic [RW-1:0]             rem_reg;
    logic [tts_pkg::CNT_W-1:0] cnt_reg;
    logic [TW-1:0]             entry_start_reg;
    logic [TW-1:0]             entry_el_reg;
    tts_pkg::rsp_t             res_reg;
    tts_pkg::rsp_t             out_data_reg;
    logic                      out_valid_reg;

    logic                      ram_we;
    logic [AW-1:0]             ram_wr_addr;
    logic [ENT_W-1:0]          ram_wr_data;
    logic [ENT_W-1:0]          ram_rd_data;
    logic                      rd_running;
    logic [TW-1:0]             rd_start;
    logic [TW-1:0]             rd_elapsed;

    logic                      conv;
    logic [RW-1:0]             mul_m;
    logic [RW-1:0]             div_d;
    logic [RW:0]               mul_sum;
    logic [WW-1:0]             mul_w_next;
    logic [RW:0]               div_r;
    logic                      div_ge;
    logic [RW-1:0]             rem_next;
    logic [WW-1:0]             div_w_next;
    logic [TW-1:0]             q_sat;
    logic [TW:0]               acc_sum;
    logic [TW-1:0]             acc_sat;
    logic [TW-1:0]             span;
    logic                      bank_full;
    logic                      id_ok;
    logic [RW-1:0]             rate_next;

    tts_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WATCHES)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (in_data.watch_id[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign rd_running = ram_rd_data[ENT_W-1];
    assign rd_start   = ram_rd_data[2*TW-1:TW];
    assign rd_elapsed = ram_rd_data[TW-1:0];

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign bank_full = (alloc_reg == AC_W'(MAX_WATCHES));
    assign id_ok     = (32'(in_data.watch_id) < 32'(alloc_reg));
    assign span      = ticks_reg - rd_start;

    // A sleep multiplies by the rate and divides by 1000; a conversion to
    // milliseconds does it the other way round.
    assign conv  = (op_reg != tts_pkg::OP_SLEEP);
    assign mul_m = conv ? tts_pkg::MS_PER_S : rate_reg;
    assign div_d = conv ? rate_reg : tts_pkg::MS_PER_S;

    // Serial-parallel multiply: the low half shifts out the multiplier bits
    // and takes in product bits, the high half is the running partial sum.
    assign mul_sum    = {1'b0, w_reg[WW-1:TW]} + (w_reg[0] ? {1'b0, mul_m} : '0);
    assign mul_w_next = {mul_sum, w_reg[TW-1:1]};

    // Restoring division: one dividend bit in and one quotient bit out a cycle.
    assign div_r      = {rem_reg, w_reg[WW-1]};
    assign div_ge     = (div_r >= {1'b0, div_d});
    assign rem_next   = div_ge ? RW'(div_r - {1'b0, div_d}) : div_r[RW-1:0];
    assign div_w_next = {w_reg[WW-2:0], div_ge};

    assign q_sat   = (w_reg[WW-1:TW] != '0) ? tts_pkg::ALL_ONES : w_reg[TW-1:0];
    assign acc_sum = {1'b0, entry_el_reg} + {1'b0, q_sat};
    assign acc_sat = acc_sum[TW] ? tts_pkg::ALL_ONES : acc_sum[TW-1:0];

    always_comb
    begin
        if (cfg_data == '0)
        begin
            rate_next = tts_pkg::RATE_MIN;
        end
        else if (cfg_data > tts_pkg::RATE_MAX)
        begin
            rate_next = tts_pkg::RATE_MAX;
        end
        else
        begin
            rate_next = cfg_data;
        end
    end

    always_comb
    begin
        ram_we      = 1'b0;
        ram_wr_addr = id_reg;
        ram_wr_data = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_data.opcode == tts_pkg::OP_CREATE && !bank_full)
                begin
                    ram_we      = 1'b1;
                    ram_wr_addr = alloc_reg[AW-1:0];
                end
            end
            S_RD:
            begin
                if (op_reg == tts_pkg::OP_START)
                begin
                    ram_we      = 1'b1;
                    ram_wr_data = {1'b1, ticks_reg, rd_elapsed};
                end
                else if (op_reg == tts_pkg::OP_RESET)
                begin
                    ram_we = 1'b1;
                end
            end
            S_POST:
            begin
                if (op_reg == tts_pkg::OP_STOP)
                begin
                    ram_we      = 1'b1;
                    ram_wr_data = {1'b0, entry_start_reg, acc_sat};
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= tts_pkg::OP_TICK;
            id_reg          <= '0;
            alloc_reg       <= '0;
            ticks_reg       <= '0;
            rate_reg        <= tts_pkg::RATE_RESET;
            w_reg           <= '0;
            rem_reg         <= '0;
            cnt_reg         <= '0;
            entry_start_reg <= '0;
            entry_el_reg    <= '0;
            res_reg         <= '0;
            out_data_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                rate_reg <= rate_next;
            end

            // In S_DONE the output register is reloaded below instead.
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg  <= in_data.opcode;
                        id_reg  <= in_data.watch_id[AW-1:0];
                        res_reg <= '0;
                        rem_reg <= '0;
                        cnt_reg <= '0;
                        case (in_data.opcode)
                            tts_pkg::OP_TICK:
                            begin
                                ticks_reg <= ticks_reg + TW'(1);
                                state_reg <= S_DONE;
                            end
                            tts_pkg::OP_SLEEP:
                            begin
                                w_reg <= WW'(in_data.sleep_ms);
                                if (in_data.sleep_ms == '0)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_MUL;
                                end
                            end
                            tts_pkg::OP_CREATE:
                            begin
                                if (bank_full)
                                begin
                                    res_reg.status <= tts_pkg::ST_FULL;
                                end
                                else
                                begin
                                    res_reg.value <= TW'(alloc_reg);
                                    alloc_reg     <= alloc_reg + AC_W'(1);
                                end
                                state_reg <= S_DONE;
                            end
                            tts_pkg::OP_UPTIME:
                            begin
                                w_reg     <= WW'(ticks_reg);
                                state_reg <= S_MUL;
                            end
                            default:
                            begin
                                if (id_ok)
                                begin
                                    state_reg <= S_RD;
                                end
                                else
                                begin
                                    res_reg.status <= tts_pkg::ST_BAD_ID;
                                    state_reg      <= S_DONE;
                                end
                            end
                        endcase
                    end
                end

                S_RD:
                begin
                    entry_start_reg <= rd_start;
                    entry_el_reg    <= rd_elapsed;
                    w_reg           <= WW'(span);
                    case (op_reg)
                        tts_pkg::OP_START:
                        begin
                            res_reg.is_running <= 1'b1;
                            state_reg          <= S_DONE;
                        end
                        tts_pkg::OP_STOP:
                        begin
                            state_reg <= rd_running ? S_MUL : S_DONE;
                        end
                        tts_pkg::OP_READ:
                        begin
                            res_reg.value <= rd_elapsed;
                            state_reg     <= rd_running ? S_MUL : S_DONE;
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end

                S_MUL:
                begin
                    w_reg <= mul_w_next;
                    if (cnt_reg == tts_pkg::CNT_W'(tts_pkg::MUL_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + tts_pkg::CNT_W'(1);
                    end
                end

                S_DIV:
                begin
                    w_reg   <= div_w_next;
                    rem_reg <= rem_next;
                    if (cnt_reg == tts_pkg::CNT_W'(tts_pkg::DIV_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_POST;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + tts_pkg::CNT_W'(1);
                    end
                end

                S_POST:
                begin
                    case (op_reg)
                        tts_pkg::OP_SLEEP:
                        begin
                            ticks_reg <= ticks_reg + w_reg[TW-1:0];
                        end
                        tts_pkg::OP_UPTIME:
                        begin
                            res_reg.value <= q_sat;
                        end
                        tts_pkg::OP_READ:
                        begin
                            res_reg.value      <= acc_sat;
                            res_reg.is_running <= 1'b1;
                        end
                        default:
                        begin
                            res_reg.is_running <= 1'b0;
                        end
                    endcase
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_data_reg  <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ dv/tb_tick_timer_stopwatch_bank_top.sv @@
// Self-checking testbench for the tick timer with its bank of stopwatches.
`timescale 1ns / 100ps

// Tracks the tick count, the tick rate and every stopwatch, and holds the
// responses still owed by the block in request order.
class tick_ledger;
    localparam int WATCHES = tts_pkg::MAX_WATCHES_DEF;

    logic [tts_pkg::TICK_W-1:0] ticks;
    logic [tts_pkg::RATE_W-1:0] rate;
    int unsigned                allocated;
    bit                         running[WATCHES];
    logic [tts_pkg::TICK_W-1:0] start_tick[WATCHES];
    logic [tts_pkg::TICK_W-1:0] elapsed_ms[WATCHES];
    tts_pkg::rsp_t              owed[$];

    int unsigned errors;
    int unsigned commands;
    int unsigned checked;
    int unsigned bad_ids;
    int unsigned full_bank;
    int unsigned live_reads;

    function new();
        ticks     = '0;
        rate      = tts_pkg::RATE_RESET;
        allocated = 0;
        for (int i = 0; i < WATCHES; i++)
        begin
            running[i]    = 1'b0;
            start_tick[i] = '0;
            elapsed_ms[i] = '0;
        end
        errors     = 0;
        commands   = 0;
        checked    = 0;
        bad_ids    = 0;
        full_bank  = 0;
        live_reads = 0;
    endfunction

    // The block clamps the written rate into its legal range.
    function void set_rate(logic [tts_pkg::RATE_W-1:0] v);
        if (v < tts_pkg::RATE_MIN)
            rate = tts_pkg::RATE_MIN;
        else if (v > tts_pkg::RATE_MAX)
            rate = tts_pkg::RATE_MAX;
        else
            rate = v;
    endfunction

    // Exact ticks * 1000 / rate, saturated when it overflows 64 bits.
    function logic [tts_pkg::TICK_W-1:0] ticks_to_ms(logic [tts_pkg::TICK_W-1:0] t);
        logic [79:0] scaled;
        logic [79:0] quot;
        scaled = {16'd0, t} * 80'd1000;
        quot   = scaled / {66'd0, rate};
        return (quot[79:64] != '0) ? tts_pkg::ALL_ONES : quot[63:0];
    endfunction

    function logic [tts_pkg::TICK_W-1:0] add_sat(logic [tts_pkg::TICK_W-1:0] a,
                                                 logic [tts_pkg::TICK_W-1:0] b);
        logic [tts_pkg::TICK_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[tts_pkg::TICK_W] ? tts_pkg::ALL_ONES : s[tts_pkg::TICK_W-1:0];
    endfunction

    function void note_command(tts_pkg::cmd_t c);
        tts_pkg::rsp_t              r;
        logic [tts_pkg::TICK_W-1:0] gained;
        int unsigned                id;
        r        = '0;
        r.status = tts_pkg::ST_OK;
        id       = int'(c.watch_id);
        commands++;
        case (c.opcode)
            tts_pkg::OP_TICK:
                ticks = ticks + tts_pkg::TICK_W'(1);
            tts_pkg::OP_SLEEP:
            begin
                gained = (64'(c.sleep_ms) * 64'(rate)) / 64'd1000;
                ticks  = ticks + gained;
            end
            tts_pkg::OP_CREATE:
            begin
                if (allocated < WATCHES)
                begin
                    running[allocated]    = 1'b0;
                    start_tick[allocated] = '0;
                    elapsed_ms[allocated] = '0;
                    r.value               = tts_pkg::TICK_W'(allocated);
                    allocated++;
                end
                else
                begin
                    r.status = tts_pkg::ST_FULL;
                    full_bank++;
                end
            end
            tts_pkg::OP_UPTIME:
                r.value = ticks_to_ms(ticks);
            default:
            begin
                if (id >= allocated)
                begin
                    r.status = tts_pkg::ST_BAD_ID;
                    bad_ids++;
                end
                else
                begin
                    case (c.opcode)
                        tts_pkg::OP_START:
                        begin
                            running[id]    = 1'b1;
                            start_tick[id] = ticks;
                        end
                        tts_pkg::OP_STOP:
                        begin
                            if (running[id])
                            begin
                                elapsed_ms[id] = add_sat(elapsed_ms[id],
                                                         ticks_to_ms(ticks - start_tick[id]));
                                running[id]    = 1'b0;
                            end
                        end
                        tts_pkg::OP_RESET:
                        begin
                            running[id]    = 1'b0;
                            start_tick[id] = '0;
                            elapsed_ms[id] = '0;
                        end
                        default:
                        begin
                            r.value = elapsed_ms[id];
                            if (running[id])
                            begin
                                r.value = add_sat(r.value, ticks_to_ms(ticks - start_tick[id]));
                                live_reads++;
                            end
                        end
                    endcase
                    r.is_running = running[id];
                end
            end
        endcase
        owed = {owed, r};
    endfunction

    task report(string msg);
        if (errors < 100)
            $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_response(tts_pkg::rsp_t got);
        tts_pkg::rsp_t want;
        if (owed.size() == 0)
        begin
            report($sformatf("response %0d arrived with nothing outstanding", checked));
        end
        else
        begin
            want = owed.pop_front();
            if (got.status !== want.status)
                report($sformatf("response %0d status %0d, predicted %0d",
                                 checked, got.status, want.status));
            if (got.value !== want.value)
                report($sformatf("response %0d value %0h, predicted %0h",
                                 checked, got.value, want.value));
            if (got.is_running !== want.is_running)
                report($sformatf("response %0d running flag %0b, predicted %0b",
                                 checked, got.is_running, want.is_running));
        end
        checked++;
    endtask
endclass

module tb_tick_timer_stopwatch_bank_top;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 210;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    tts_pkg::cmd_t              in_data;
    logic                       out_valid;
    logic                       out_stall;
    tts_pkg::rsp_t              out_data;
    logic                       cfg_we;
    logic [tts_pkg::RATE_W-1:0] cfg_data;

    tick_ledger ledger = new();
    bit         sender_calm = 1'b0;

    tick_timer_stopwatch_bank_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_calm || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic tts_pkg::cmd_t make_cmd(tts_pkg::opcode_t op,
                                               logic [tts_pkg::ID_W-1:0] id,
                                               logic [tts_pkg::SLEEP_W-1:0] ms);
        tts_pkg::cmd_t c;
        c.opcode   = op;
        c.watch_id = id;
        c.sleep_ms = ms;
        return c;
    endfunction

    // Mostly valid ids and short sleeps, so that watches run and get read;
    // the rest reaches every id and every sleep bit.
    function automatic tts_pkg::cmd_t random_cmd();
        int                          r;
        tts_pkg::opcode_t            op;
        logic [tts_pkg::ID_W-1:0]    id;
        logic [tts_pkg::SLEEP_W-1:0] ms;
        r = $urandom_range(0, 99);
        if (r < 20)
            op = tts_pkg::OP_TICK;
        else if (r < 34)
            op = tts_pkg::OP_SLEEP;
        else if (r < 42)
            op = tts_pkg::OP_CREATE;
        else if (r < 54)
            op = tts_pkg::OP_START;
        else if (r < 66)
            op = tts_pkg::OP_STOP;
        else if (r < 71)
            op = tts_pkg::OP_RESET;
        else if (r < 87)
            op = tts_pkg::OP_READ;
        else
            op = tts_pkg::OP_UPTIME;
        if ($urandom_range(0, 9) < 8)
            id = tts_pkg::ID_W'($urandom_range(0, tts_pkg::MAX_WATCHES_DEF - 1));
        else
            id = tts_pkg::ID_W'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        if (r == 0)
            ms = '0;
        else if (r == 1)
            ms = tts_pkg::SLEEP_W'($urandom);
        else
            ms = tts_pkg::SLEEP_W'($urandom_range(1, 3000));
        return make_cmd(op, id, ms);
    endfunction

    // Offers one request, waits for the edge that takes it and then for a random
    // gap; the valid line is left high when the next request follows without a gap.
    task send_command(tts_pkg::cmd_t c);
        int gap;
        in_data  <= c;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ledger.note_command(c);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task settle();
        in_valid <= 1'b0;
        while (ledger.owed.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_rate(logic [tts_pkg::RATE_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        ledger.set_rate(v);
    endtask

    // Response side: checks every accepted response and drives the stall,
    // with one long hold-off that lets the block back up into its input.
    initial
    begin
        int stall_left;
        bit calm;
        bit held;
        out_stall <= 1'b0;
        stall_left = 0;
        calm       = 1'b0;
        held       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                ledger.check_response(out_data);
            if (!held && ledger.checked == 500)
            begin
                held       = 1'b1;
                stall_left = 600;
            end
            if ($urandom_range(0, 299) == 0)
                calm = !calm;
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (calm || $urandom_range(0, 99) < 70)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b1;
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(8, 50);
            end
        end
    end

    initial
    begin
        tts_pkg::cmd_t              directed[$];
        logic [tts_pkg::RATE_W-1:0] rate_plan[PHASES];
        int                         pause_at;
        int                         waited;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        rate_plan[0] = tts_pkg::RATE_W'(1);
        rate_plan[1] = tts_pkg::RATE_MAX;
        rate_plan[2] = '0;
        rate_plan[3] = '1;
        rate_plan[4] = tts_pkg::RATE_W'($urandom_range(2, 9999));
        rate_plan[5] = tts_pkg::RATE_RESET;
        rate_plan[6] = tts_pkg::RATE_W'(37);
        rate_plan[7] = tts_pkg::RATE_W'($urandom);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset rate: empty bank, zero and maximum
        // sleeps, stop of a stopped watch, restart, watch reset, bad ids.
        directed = {directed, make_cmd(tts_pkg::OP_UPTIME, '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_READ,   '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_STOP,   '1, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_CREATE, '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_CREATE, '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_READ,   tts_pkg::ID_W'(1), '0)};
        directed = {directed, make_cmd(tts_pkg::OP_START,  '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_TICK,   '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_SLEEP,  '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_SLEEP,  '1, '1)};
        directed = {directed, make_cmd(tts_pkg::OP_READ,   '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_STOP,   '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_STOP,   '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_START,  '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_START,  '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_SLEEP,  '0, tts_pkg::SLEEP_W'(1))};
        directed = {directed, make_cmd(tts_pkg::OP_READ,   '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_RESET,  '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_READ,   '0, '0)};
        directed = {directed, make_cmd(tts_pkg::OP_START,  tts_pkg::ID_W'(1), '0)};
        directed = {directed, make_cmd(tts_pkg::OP_UPTIME, '1, '1)};
        directed = {directed, make_cmd(tts_pkg::OP_START,  tts_pkg::ID_W'(2), '0)};
        directed = {directed, make_cmd(tts_pkg::OP_TICK,   '1, '1)};
        foreach (directed[i])
            send_command(directed[i]);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_rate(rate_plan[p]);
            pause_at = $urandom_range(30, 180);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == pause_at)
                    settle();
                if ($urandom_range(0, 49) == 0)
                    sender_calm = !sender_calm;
                send_command(random_cmd());
            end
        end

        in_valid <= 1'b0;
        waited = 0;
        while (ledger.owed.size() != 0 && waited < 50000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (ledger.owed.size() != 0)
            ledger.report($sformatf("%0d responses never arrived", ledger.owed.size()));

        $display("%0d commands under %0d tick rates, %0d responses checked",
                 ledger.commands, PHASES + 1, ledger.checked);
        $display("%0d bad-id, %0d bank-full and %0d running-watch reads among them",
                 ledger.bad_ids, ledger.full_bank, ledger.live_reads);
        if (ledger.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
